[design/apw_pkg.sv]
`timescale 1ns / 1ps
package apw_pkg;

  localparam int unsigned LastKnotDef  = 39;
  localparam int unsigned CoordBitsDef = 32;
  localparam int unsigned CordicSteps  = 32;
  localparam int unsigned SqrtSteps    = 64;
  localparam int unsigned DivSteps     = 34;
  localparam int unsigned KnotIdxW     = 6;

  localparam logic [31:0] WeightOne  = 32'h4000_0000;
  localparam logic [31:0] TenDegrees = 32'hA000_0000;

  // one input beat: two positions
  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
  } apw_item_t;

  // one result beat
  typedef struct packed {
    logic [31:0] pair_weight;
    logic        zero_vector;
  } apw_result_t;

  // side flags that ride along with every item
  typedef struct packed {
    logic zero_vec;
    logic force_one;
  } apw_tag_t;

  // angle handed from the CORDIC to the interpolator
  typedef struct packed {
    logic               vld;
    apw_tag_t           tag;
    logic signed [39:0] angle;
  } apw_angle_t;

  // atan(2^-i) in degrees, Q8.28
  function automatic logic [35:0] angle_step(logic [4:0] i);
    logic [35:0] r;
    case (i)
      5'd0:  r = 36'd12079595520;
      5'd1:  r = 36'd7131001627;
      5'd2:  r = 36'd3767825416;
      5'd3:  r = 36'd1912607013;
      5'd4:  r = 36'd960014949;
      5'd5:  r = 36'd480475470;
      5'd6:  r = 36'd240296363;
      5'd7:  r = 36'd120155514;
      5'd8:  r = 36'd60078674;
      5'd9:  r = 36'd30039451;
      5'd10: r = 36'd15019740;
      5'd11: r = 36'd7509872;
      5'd12: r = 36'd3754936;
      5'd13: r = 36'd1877468;
      5'd14: r = 36'd938734;
      5'd15: r = 36'd469367;
      5'd16: r = 36'd234684;
      5'd17: r = 36'd117342;
      5'd18: r = 36'd58671;
      5'd19: r = 36'd29335;
      5'd20: r = 36'd14668;
      5'd21: r = 36'd7334;
      5'd22: r = 36'd3667;
      5'd23: r = 36'd1833;
      5'd24: r = 36'd917;
      5'd25: r = 36'd458;
      5'd26: r = 36'd229;
      5'd27: r = 36'd115;
      5'd28: r = 36'd57;
      5'd29: r = 36'd29;
      5'd30: r = 36'd14;
      5'd31: r = 36'd7;
      default: r = 36'd0;
    endcase
    return r;
  endfunction

  // breakpoint angles, Q4.28 degrees; indices past the table read the last knot
  function automatic logic [31:0] knot_x(logic [KnotIdxW-1:0] i);
    logic [31:0] r;
    case (i)
      6'd0:  r = 32'd0;
      6'd1:  r = 32'd379175;
      6'd2:  r = 32'd477353;
      6'd3:  r = 32'd600952;
      6'd4:  r = 32'd756554;
      6'd5:  r = 32'd952445;
      6'd6:  r = 32'd1199057;
      6'd7:  r = 32'd1509523;
      6'd8:  r = 32'd1900378;
      6'd9:  r = 32'd2392433;
      6'd10: r = 32'd3011894;
      6'd11: r = 32'd3791753;
      6'd12: r = 32'd4773532;
      6'd13: r = 32'd6009521;
      6'd14: r = 32'd7565539;
      6'd15: r = 32'd9524450;
      6'd16: r = 32'd11990572;
      6'd17: r = 32'd15095234;
      6'd18: r = 32'd19003775;
      6'd19: r = 32'd23924334;
      6'd20: r = 32'd30118941;
      6'd21: r = 32'd37917528;
      6'd22: r = 32'd47735322;
      6'd23: r = 32'd60095209;
      6'd24: r = 32'd75655392;
      6'd25: r = 32'd95244497;
      6'd26: r = 32'd119905715;
      6'd27: r = 32'd150952343;
      6'd28: r = 32'd190037753;
      6'd29: r = 32'd239243342;
      6'd30: r = 32'd301189414;
      6'd31: r = 32'd379175282;
      6'd32: r = 32'd477353220;
      6'd33: r = 32'd600952090;
      6'd34: r = 32'd756553920;
      6'd35: r = 32'd952444970;
      6'd36: r = 32'd1199057150;
      6'd37: r = 32'd1509523430;
      6'd38: r = 32'd1900377530;
      default: r = 32'd2711198106;
    endcase
    return r;
  endfunction

  // weights at the breakpoints, Q2.30
  function automatic logic [31:0] knot_y(logic [KnotIdxW-1:0] i);
    logic [31:0] r;
    case (i)
      6'd0:  r = 32'd1439745988;
      6'd1:  r = 32'd1448283126;
      6'd2:  r = 32'd1461413282;
      6'd3:  r = 32'd1429598902;
      6'd4:  r = 32'd1438405357;
      6'd5:  r = 32'd1427908897;
      6'd6:  r = 32'd1421105508;
      6'd7:  r = 32'd1412080729;
      6'd8:  r = 32'd1401533245;
      6'd9:  r = 32'd1341505246;
      6'd10: r = 32'd1306819091;
      6'd11: r = 32'd1285182635;
      6'd12: r = 32'd1256965075;
      6'd13: r = 32'd1230518954;
      6'd14: r = 32'd1202269558;
      6'd15: r = 32'd1176202220;
      6'd16: r = 32'd1154483720;
      6'd17: r = 32'd1139757318;
      6'd18: r = 32'd1126274310;
      6'd19: r = 32'd1116062295;
      6'd20: r = 32'd1107861259;
      6'd21: r = 32'd1101457291;
      6'd22: r = 32'd1096079111;
      6'd23: r = 32'd1091890724;
      6'd24: r = 32'd1088691349;
      6'd25: r = 32'd1086033763;
      6'd26: r = 32'd1083914744;
      6'd27: r = 32'd1082142544;
      6'd28: r = 32'd1080390874;
      6'd29: r = 32'd1078973352;
      6'd30: r = 32'd1078288509;
      6'd31: r = 32'd1077664643;
      6'd32: r = 32'd1076460420;
      6'd33: r = 32'd1075562471;
      6'd34: r = 32'd1074880334;
      6'd35: r = 32'd1074532001;
      6'd36: r = 32'd1074023832;
      6'd37: r = 32'd1073709010;
      6'd38: r = 32'd1073500586;
      default: r = 32'd1073444043;
    endcase
    return r;
  endfunction

endpackage

[design/angular_pair_weight_core.sv]
`timescale 1ns / 1ps
// Pair weight 1 + w(theta) from the angle between two integer 3D positions.
//
// Command channel: present both positions on item_i and raise start; the beat
// is taken at every edge where start is high and busy is low. busy is never
// raised, so one pair can enter in every clock cycle.
// Result channel: done_o is high for exactly one cycle with pair_weight
// (unsigned Q2.30) and zero_vector on result_o. There is no back-pressure;
// the receiver must take every result beat.
// The depth is set by the 64-stage square root of the squared cross norm,
// the 32-stage CORDIC and the 34-stage restoring divider of the interpolation.
// Throughput: one pair per cycle, results in order of acceptance.
// Reset: clears every valid bit; items in flight are dropped and no result
// beat comes out of reset.
// A zero-length vector returns weight one with zero_vector set; an angle of
// ninety degrees or more, or above ten degrees, returns weight one.
module angular_pair_weight_core #(
  parameter int unsigned LastKnot  = apw_pkg::LastKnotDef,
  parameter int unsigned CoordBits = apw_pkg::CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  apw_pkg::apw_item_t   item_i,
  output logic                 done_o,
  output apw_pkg::apw_result_t result_o
);
  import apw_pkg::*;

  localparam int unsigned Pad         = 32 - CoordBits;
  localparam int unsigned SearchSteps = (LastKnot > 1) ? $clog2(LastKnot) : 1;
  localparam int unsigned Latency     = 148 + SearchSteps;

  assign busy = 1'b0;

  // ---------------- stage 1: sign-extend and multiply
  logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z;
  logic               accept;

  always_comb begin
    accept = start && !busy;
    a_x = $signed(item_i.first_x  << Pad) >>> Pad;
    a_y = $signed(item_i.first_y  << Pad) >>> Pad;
    a_z = $signed(item_i.first_z  << Pad) >>> Pad;
    b_x = $signed(item_i.second_x << Pad) >>> Pad;
    b_y = $signed(item_i.second_y << Pad) >>> Pad;
    b_z = $signed(item_i.second_z << Pad) >>> Pad;
  end

  logic               vld_s1_q;
  logic               zero_s1_q;
  logic signed [63:0] dx_s1_q, dy_s1_q, dz_s1_q;
  logic signed [63:0] yz_s1_q, zy_s1_q, zx_s1_q, xz_s1_q, xy_s1_q, yx_s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s1_q <= 1'b0;
    end else begin
      vld_s1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_s1_q <= ((a_x == '0) && (a_y == '0) && (a_z == '0)) ||
                 ((b_x == '0) && (b_y == '0) && (b_z == '0));
    dx_s1_q <= a_x * b_x;
    dy_s1_q <= a_y * b_y;
    dz_s1_q <= a_z * b_z;
    yz_s1_q <= a_y * b_z;
    zy_s1_q <= a_z * b_y;
    zx_s1_q <= a_z * b_x;
    xz_s1_q <= a_x * b_z;
    xy_s1_q <= a_x * b_y;
    yx_s1_q <= a_y * b_x;
  end

  // ---------------- stage 2: dot product and cross components
  logic signed [65:0] dot;
  logic signed [64:0] dcx, dcy, dcz;

  always_comb begin
    dot = 66'(dx_s1_q) + 66'(dy_s1_q) + 66'(dz_s1_q);
    dcx = 65'(yz_s1_q) - 65'(zy_s1_q);
    dcy = 65'(zx_s1_q) - 65'(xz_s1_q);
    dcz = 65'(xy_s1_q) - 65'(yx_s1_q);
  end

  logic        vld_s2_q;
  apw_tag_t    tag_s2_q;
  logic [63:0] dot_s2_q, cx_s2_q, cy_s2_q, cz_s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s2_q <= 1'b0;
    end else begin
      vld_s2_q <= vld_s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_s2_q.zero_vec  <= zero_s1_q;
    tag_s2_q.force_one <= dot[65] || (dot == '0);
    dot_s2_q <= dot[63:0];
    cx_s2_q  <= dcx[64] ? 64'(-dcx) : dcx[63:0];
    cy_s2_q  <= dcy[64] ? 64'(-dcy) : dcy[63:0];
    cz_s2_q  <= dcz[64] ? 64'(-dcz) : dcz[63:0];
  end

  // ---------------- stage 3: partial products of the squares
  logic        vld_s3_q;
  apw_tag_t    tag_s3_q;
  logic [63:0] dot_s3_q;
  logic [63:0] hh_s3_q [3];
  logic [63:0] hl_s3_q [3];
  logic [63:0] ll_s3_q [3];
  logic [63:0] comp    [3];

  always_comb begin
    comp[0] = cx_s2_q;
    comp[1] = cy_s2_q;
    comp[2] = cz_s2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s3_q <= 1'b0;
    end else begin
      vld_s3_q <= vld_s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_s3_q <= tag_s2_q;
    dot_s3_q <= dot_s2_q;
    for (int i = 0; i < 3; i++) begin
      hh_s3_q[i] <= 64'(comp[i][63:32]) * 64'(comp[i][63:32]);
      hl_s3_q[i] <= 64'(comp[i][63:32]) * 64'(comp[i][31:0]);
      ll_s3_q[i] <= 64'(comp[i][31:0])  * 64'(comp[i][31:0]);
    end
  end

  // ---------------- stage 4: assemble each square
  logic         vld_s4_q;
  apw_tag_t     tag_s4_q;
  logic [63:0]  dot_s4_q;
  logic [127:0] sq_s4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s4_q <= 1'b0;
    end else begin
      vld_s4_q <= vld_s3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_s4_q <= tag_s3_q;
    dot_s4_q <= dot_s3_q;
    for (int i = 0; i < 3; i++) begin
      sq_s4_q[i] <= {hh_s3_q[i], 64'd0} + (128'(hl_s3_q[i]) << 33) + 128'(ll_s3_q[i]);
    end
  end

  // ---------------- square root of the squared cross norm, one root bit per stage
  logic         vld_sq_q  [SqrtSteps+1];
  apw_tag_t     tag_sq_q  [SqrtSteps+1];
  logic [63:0]  dot_sq_q  [SqrtSteps+1];
  logic [127:0] num_sq_q  [SqrtSteps+1];
  logic [65:0]  rem_sq_q  [SqrtSteps+1];
  logic [63:0]  root_sq_q [SqrtSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_sq_q[0] <= 1'b0;
    end else begin
      vld_sq_q[0] <= vld_s4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_sq_q[0]  <= tag_s4_q;
    dot_sq_q[0]  <= dot_s4_q;
    num_sq_q[0]  <= sq_s4_q[0] + sq_s4_q[1] + sq_s4_q[2];
    rem_sq_q[0]  <= '0;
    root_sq_q[0] <= '0;
  end

  for (genvar s = 0; s < SqrtSteps; s++) begin : g_sqrt
    logic [67:0] rem_t, trial;

    always_comb begin
      rem_t = {rem_sq_q[s], num_sq_q[s][127:126]};
      trial = 68'({root_sq_q[s], 2'b01});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_sq_q[s+1] <= 1'b0;
      end else begin
        vld_sq_q[s+1] <= vld_sq_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rem_t >= trial) begin
        rem_sq_q[s+1]  <= 66'(rem_t - trial);
        root_sq_q[s+1] <= {root_sq_q[s][62:0], 1'b1};
      end else begin
        rem_sq_q[s+1]  <= rem_t[65:0];
        root_sq_q[s+1] <= {root_sq_q[s][62:0], 1'b0};
      end
      num_sq_q[s+1] <= num_sq_q[s] << 2;
      tag_sq_q[s+1] <= tag_sq_q[s];
      dot_sq_q[s+1] <= dot_sq_q[s];
    end
  end

  // ---------------- normalise so the larger leg has its top bit at 63
  localparam int unsigned NormSteps = 6;

  logic        vld_nm_q [NormSteps+1];
  apw_tag_t    tag_nm_q [NormSteps+1];
  logic [63:0] dot_nm_q [NormSteps+1];
  logic [63:0] cn_nm_q  [NormSteps+1];
  logic [63:0] big_nm_q [NormSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_nm_q[0] <= 1'b0;
    end else begin
      vld_nm_q[0] <= vld_sq_q[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    tag_nm_q[0] <= tag_sq_q[SqrtSteps];
    dot_nm_q[0] <= dot_sq_q[SqrtSteps];
    cn_nm_q[0]  <= root_sq_q[SqrtSteps];
    big_nm_q[0] <= (dot_sq_q[SqrtSteps] > root_sq_q[SqrtSteps]) ?
                   dot_sq_q[SqrtSteps] : root_sq_q[SqrtSteps];
  end

  for (genvar k = 0; k < NormSteps; k++) begin : g_norm
    localparam int unsigned Amt = 32 >> k;
    logic shl;

    assign shl = (big_nm_q[k][63 -: Amt] == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_nm_q[k+1] <= 1'b0;
      end else begin
        vld_nm_q[k+1] <= vld_nm_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      tag_nm_q[k+1] <= tag_nm_q[k];
      dot_nm_q[k+1] <= shl ? (dot_nm_q[k] << Amt) : dot_nm_q[k];
      cn_nm_q[k+1]  <= shl ? (cn_nm_q[k]  << Amt) : cn_nm_q[k];
      big_nm_q[k+1] <= shl ? (big_nm_q[k] << Amt) : big_nm_q[k];
    end
  end

  // ---------------- CORDIC vectoring, one rotation per stage
  logic               vld_cr_q [CordicSteps+1];
  apw_tag_t           tag_cr_q [CordicSteps+1];
  logic signed [63:0] x_cr_q   [CordicSteps+1];
  logic signed [63:0] y_cr_q   [CordicSteps+1];
  logic signed [39:0] z_cr_q   [CordicSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_cr_q[0] <= 1'b0;
    end else begin
      vld_cr_q[0] <= vld_nm_q[NormSteps];
    end
  end

  // drop three bits: the top bit moves from 63 to 60
  always_ff @(posedge clk_i) begin
    tag_cr_q[0] <= tag_nm_q[NormSteps];
    x_cr_q[0]   <= $signed({3'b000, dot_nm_q[NormSteps][63:3]});
    y_cr_q[0]   <= $signed({3'b000, cn_nm_q[NormSteps][63:3]});
    z_cr_q[0]   <= '0;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    logic signed [39:0] step;
    logic signed [63:0] ddx, ddy;

    always_comb begin
      step = $signed({4'b0000, angle_step(5'(i))});
      ddx  = y_cr_q[i] >>> i;
      ddy  = x_cr_q[i] >>> i;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_cr_q[i+1] <= 1'b0;
      end else begin
        vld_cr_q[i+1] <= vld_cr_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      tag_cr_q[i+1] <= tag_cr_q[i];
      if (!y_cr_q[i][63]) begin
        x_cr_q[i+1] <= x_cr_q[i] + ddx;
        y_cr_q[i+1] <= y_cr_q[i] - ddy;
        z_cr_q[i+1] <= z_cr_q[i] + step;
      end else begin
        x_cr_q[i+1] <= x_cr_q[i] - ddx;
        y_cr_q[i+1] <= y_cr_q[i] + ddy;
        z_cr_q[i+1] <= z_cr_q[i] - step;
      end
    end
  end

  // ---------------- table search and interpolation
  apw_angle_t angle;

  always_comb begin
    angle.vld   = vld_cr_q[CordicSteps];
    angle.tag   = tag_cr_q[CordicSteps];
    angle.angle = z_cr_q[CordicSteps];
  end

  apw_interp #(
    .LastKnot    (LastKnot),
    .SearchSteps (SearchSteps)
  ) u_apw_interp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .angle_i  (angle),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

[design/apw_interp.sv]
`timescale 1ns / 1ps
module apw_interp #(
  parameter int unsigned LastKnot    = apw_pkg::LastKnotDef,
  parameter int unsigned SearchSteps = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  apw_pkg::apw_angle_t  angle_i,
  output logic                 done_o,
  output apw_pkg::apw_result_t result_o
);
  import apw_pkg::*;

  // ---------------- search pipeline, element 0 takes the clamped angle
  logic                vld_sr_q [SearchSteps+1];
  logic [KnotIdxW-1:0] lo_sr_q  [SearchSteps+1];
  logic [KnotIdxW-1:0] hi_sr_q  [SearchSteps+1];
  logic [31:0]         t_sr_q   [SearchSteps+1];
  apw_tag_t            tag_sr_q [SearchSteps+1];

  logic     ang_neg, ang_over;
  apw_tag_t tag_in;

  // clamp negative angles to zero and flag anything above ten degrees
  always_comb begin
    ang_neg  = angle_i.angle[39];
    ang_over = !ang_neg && ((angle_i.angle[38:32] != '0) ||
                            (angle_i.angle[31:0] > TenDegrees));
    tag_in   = angle_i.tag;
    tag_in.force_one = angle_i.tag.force_one | ang_over;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_sr_q[0] <= 1'b0;
    end else begin
      vld_sr_q[0] <= angle_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_sr_q[0]  <= '0;
    hi_sr_q[0]  <= KnotIdxW'(LastKnot);
    t_sr_q[0]   <= ang_neg ? 32'd0 : angle_i.angle[31:0];
    tag_sr_q[0] <= tag_in;
  end

  // one halving of the knot interval per stage
  for (genvar s = 0; s < SearchSteps; s++) begin : g_search
    logic [KnotIdxW-1:0] mid;
    logic                go;

    always_comb begin
      mid = KnotIdxW'((({1'b0, lo_sr_q[s]}) + ({1'b0, hi_sr_q[s]})) >> 1);
      go  = (hi_sr_q[s] - lo_sr_q[s]) > KnotIdxW'(1);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_sr_q[s+1] <= 1'b0;
      end else begin
        vld_sr_q[s+1] <= vld_sr_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      lo_sr_q[s+1]  <= lo_sr_q[s];
      hi_sr_q[s+1]  <= hi_sr_q[s];
      if (go) begin
        if (t_sr_q[s] > knot_x(mid)) begin
          lo_sr_q[s+1] <= mid;
        end else begin
          hi_sr_q[s+1] <= mid;
        end
      end
      t_sr_q[s+1]   <= t_sr_q[s];
      tag_sr_q[s+1] <= tag_sr_q[s];
    end
  end

  // ---------------- read the interval ends
  logic        vld_lk_q, up_lk_q, nospan_lk_q;
  logic [31:0] dt_lk_q, dy_lk_q, y0_lk_q, span_lk_q;
  apw_tag_t    tag_lk_q;
  logic [31:0] x0, x1, y0, y1;
  logic [32:0] span;

  always_comb begin
    x0   = knot_x(lo_sr_q[SearchSteps]);
    x1   = knot_x(lo_sr_q[SearchSteps] + KnotIdxW'(1));
    y0   = knot_y(lo_sr_q[SearchSteps]);
    y1   = knot_y(lo_sr_q[SearchSteps] + KnotIdxW'(1));
    span = {1'b0, x1} - {1'b0, x0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_lk_q <= 1'b0;
    end else begin
      vld_lk_q <= vld_sr_q[SearchSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    dt_lk_q     <= t_sr_q[SearchSteps] - x0;
    up_lk_q     <= y1 >= y0;
    dy_lk_q     <= (y1 >= y0) ? (y1 - y0) : (y0 - y1);
    y0_lk_q     <= y0;
    span_lk_q   <= span[31:0];
    nospan_lk_q <= span[32] || (span == '0);
    tag_lk_q    <= tag_sr_q[SearchSteps];
  end

  // ---------------- step magnitude
  logic        vld_ml_q, up_ml_q, nospan_ml_q;
  logic [63:0] mag_ml_q;
  logic [31:0] y0_ml_q, span_ml_q;
  apw_tag_t    tag_ml_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_ml_q <= 1'b0;
    end else begin
      vld_ml_q <= vld_lk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_ml_q    <= 64'(dy_lk_q) * 64'(dt_lk_q);
    up_ml_q     <= up_lk_q;
    nospan_ml_q <= nospan_lk_q;
    y0_ml_q     <= y0_lk_q;
    span_ml_q   <= span_lk_q;
    tag_ml_q    <= tag_lk_q;
  end

  // ---------------- restoring divider, one quotient bit per stage
  logic                vld_dv_q  [DivSteps+1];
  logic [31:0]         rem_dv_q  [DivSteps+1];
  logic [DivSteps-1:0] num_dv_q  [DivSteps+1];
  logic [DivSteps-1:0] quo_dv_q  [DivSteps+1];
  logic                ovf_dv_q  [DivSteps+1];
  logic                up_dv_q   [DivSteps+1];
  logic                nosp_dv_q [DivSteps+1];
  logic [31:0]         y0_dv_q   [DivSteps+1];
  logic [31:0]         span_dv_q [DivSteps+1];
  apw_tag_t            tag_dv_q  [DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_dv_q[0] <= 1'b0;
    end else begin
      vld_dv_q[0] <= vld_ml_q;
    end
  end

  // a quotient past the weight range saturates, so flag it up front
  always_ff @(posedge clk_i) begin
    rem_dv_q[0]  <= 32'(mag_ml_q[63:DivSteps]);
    num_dv_q[0]  <= mag_ml_q[DivSteps-1:0];
    quo_dv_q[0]  <= '0;
    ovf_dv_q[0]  <= 32'(mag_ml_q[63:DivSteps]) >= span_ml_q;
    up_dv_q[0]   <= up_ml_q;
    nosp_dv_q[0] <= nospan_ml_q;
    y0_dv_q[0]   <= y0_ml_q;
    span_dv_q[0] <= span_ml_q;
    tag_dv_q[0]  <= tag_ml_q;
  end

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    logic [32:0] rem_t, rem_s;

    always_comb begin
      rem_t = {rem_dv_q[s], num_dv_q[s][DivSteps-1]};
      rem_s = rem_t - {1'b0, span_dv_q[s]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_dv_q[s+1] <= 1'b0;
      end else begin
        vld_dv_q[s+1] <= vld_dv_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rem_t >= {1'b0, span_dv_q[s]}) begin
        rem_dv_q[s+1] <= rem_s[31:0];
        quo_dv_q[s+1] <= {quo_dv_q[s][DivSteps-2:0], 1'b1};
      end else begin
        rem_dv_q[s+1] <= rem_t[31:0];
        quo_dv_q[s+1] <= {quo_dv_q[s][DivSteps-2:0], 1'b0};
      end
      num_dv_q[s+1]  <= num_dv_q[s] << 1;
      ovf_dv_q[s+1]  <= ovf_dv_q[s];
      up_dv_q[s+1]   <= up_dv_q[s];
      nosp_dv_q[s+1] <= nosp_dv_q[s];
      y0_dv_q[s+1]   <= y0_dv_q[s];
      span_dv_q[s+1] <= span_dv_q[s];
      tag_dv_q[s+1]  <= tag_dv_q[s];
    end
  end

  // ---------------- apply the step to y0 and saturate
  logic [DivSteps:0]   sum_up;
  logic [DivSteps-1:0] q;
  logic [31:0]         weight;
  apw_tag_t            tag_f;

  always_comb begin
    q      = quo_dv_q[DivSteps];
    tag_f  = tag_dv_q[DivSteps];
    sum_up = (DivSteps+1)'(y0_dv_q[DivSteps]) + (DivSteps+1)'(q);
    if (tag_f.force_one || tag_f.zero_vec) begin
      weight = WeightOne;
    end else if (nosp_dv_q[DivSteps]) begin
      weight = y0_dv_q[DivSteps];
    end else if (up_dv_q[DivSteps]) begin
      if (ovf_dv_q[DivSteps] || (sum_up[DivSteps:32] != '0)) begin
        weight = 32'hFFFF_FFFF;
      end else begin
        weight = sum_up[31:0];
      end
    end else begin
      if (ovf_dv_q[DivSteps] || (q > DivSteps'(y0_dv_q[DivSteps]))) begin
        weight = 32'd0;
      end else begin
        weight = y0_dv_q[DivSteps] - q[31:0];
      end
    end
  end

  logic        done_q;
  apw_result_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_dv_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.pair_weight <= weight;
    result_q.zero_vector <= tag_f.zero_vec;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

[design/apw_checker.sv]
`timescale 1ns / 1ps
module apw_checker #(
  parameter int unsigned Latency = 154
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input apw_pkg::apw_item_t   item_i,
  input logic                 done_o,
  input apw_pkg::apw_result_t result_o
);
  import apw_pkg::*;

  // every accepted beat comes out after the fixed pipeline depth
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("accepted beat produced no result");

  // no result without a matching accepted beat
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without accepted beat");

  // a zero-length vector always gives weight one
  a_zero_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.zero_vector) |-> (result_o.pair_weight == WeightOne))
    else $error("zero vector with weight other than one");

  // an all-zero first position is flagged in its own result
  a_zero_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.first_x == '0) && (item_i.first_y == '0) &&
     (item_i.first_z == '0)) |-> ##Latency (done_o && result_o.zero_vector))
    else $error("zero vector not flagged");

endmodule

bind angular_pair_weight_core apw_checker #(
  .Latency (Latency)
) u_apw_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import apw_pkg::*;

  localparam longint TenDeg = 64'sd2684354560;

  localparam longint AtanDeg [32] = '{
    64'sd12079595520, 64'sd7131001627, 64'sd3767825416, 1912607013, 960014949, 480475470,
    240296363, 120155514, 60078674, 30039451, 15019740, 7509872, 3754936,
    1877468, 938734, 469367, 234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  localparam longint BreakAngle [40] = '{
    0, 379175, 477353, 600952, 756554, 952445, 1199057, 1509523, 1900378,
    2392433, 3011894, 3791753, 4773532, 6009521, 7565539, 9524450, 11990572,
    15095234, 19003775, 23924334, 30118941, 37917528, 47735322, 60095209,
    75655392, 95244497, 119905715, 150952343, 190037753, 239243342,
    301189414, 379175282, 477353220, 600952090, 756553920, 952444970,
    1199057150, 1509523430, 1900377530, 64'sd2711198106
  };

  localparam longint BreakWeight [40] = '{
    1439745988, 1448283126, 1461413282, 1429598902, 1438405357, 1427908897,
    1421105508, 1412080729, 1401533245, 1341505246, 1306819091, 1285182635,
    1256965075, 1230518954, 1202269558, 1176202220, 1154483720, 1139757318,
    1126274310, 1116062295, 1107861259, 1101457291, 1096079111, 1091890724,
    1088691349, 1086033763, 1083914744, 1082142544, 1080390874, 1078973352,
    1078288509, 1077664643, 1076460420, 1075562471, 1074880334, 1074532001,
    1074023832, 1073709010, 1073500586, 1073444043
  };

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  apw_item_t   item_i;
  logic        done_o;
  apw_result_t result_o;

  apw_item_t   pending_pairs[$];
  apw_result_t expected_weights[$];
  int          issued_cnt;
  int          taken_cnt;
  int          burst_left;
  int          gap_left;
  int          fail_cnt;
  bit          stim_done;

  angular_pair_weight_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // linear interpolation between breakpoints, angle in Q4.28 degrees
  function automatic longint interp_weight(longint t);
    int     lo;
    int     hi;
    int     mid;
    longint x0;
    longint x1;
    longint y0;
    longint y1;
    longint w;
    bit [63:0] mag;
    bit [63:0] q;
    lo = 0;
    hi = 39;
    while (hi - lo > 1) begin
      mid = (hi + lo) / 2;
      if (t > BreakAngle[mid]) lo = mid;
      else hi = mid;
    end
    x0 = BreakAngle[lo];
    x1 = BreakAngle[lo + 1];
    y0 = BreakWeight[lo];
    y1 = BreakWeight[lo + 1];
    if (x1 - x0 <= 0) begin
      w = y0;
    end else begin
      mag = 64'(y1 >= y0 ? y1 - y0 : y0 - y1) * 64'(t - x0);
      q = mag / 64'(x1 - x0);
      if (q > 64'hFF_FFFF_FFFF) q = 64'hFF_FFFF_FFFF;
      w = (y1 >= y0) ? y0 + longint'(q) : y0 - longint'(q);
    end
    if (w < 0) w = 0;
    if (w > 64'sh0_FFFF_FFFF) w = 64'sh0_FFFF_FFFF;
    return w;
  endfunction

  // weight of one pair from the angle between the two positions
  function automatic apw_result_t pair_weight_of(apw_item_t it);
    apw_result_t r;
    longint      a[3];
    longint      b[3];
    longint      p;
    longint      u;
    longint      v;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    bit [63:0]   pos;
    bit [63:0]   neg;
    bit [63:0]   dotv;
    bit [63:0]   cr[3];
    bit [63:0]   cn;
    bit [63:0]   cand;
    bit [63:0]   big;
    bit [127:0]  csq;
    int          top;
    a = '{it.first_x, it.first_y, it.first_z};
    b = '{it.second_x, it.second_y, it.second_z};
    r.pair_weight = WeightOne;
    r.zero_vector = 1'b0;
    if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
      r.zero_vector = 1'b1;
      return r;
    end
    pos = 0;
    neg = 0;
    for (int i = 0; i < 3; i++) begin
      p = a[i] * b[i];
      if (p >= 0) pos += 64'(p);
      else neg += 64'(-p);
    end
    if (pos <= neg) return r;
    dotv = pos - neg;
    for (int i = 0; i < 3; i++) begin
      u = a[(i + 1) % 3] * b[(i + 2) % 3];
      v = a[(i + 2) % 3] * b[(i + 1) % 3];
      cr[i] = (u >= v) ? 64'(u) - 64'(v) : 64'(v) - 64'(u);
    end
    csq = 128'(cr[0]) * 128'(cr[0]) + 128'(cr[1]) * 128'(cr[1]) + 128'(cr[2]) * 128'(cr[2]);
    // floor square root of the squared cross norm
    cn = 0;
    for (int k = 63; k >= 0; k--) begin
      cand = cn | (64'd1 << k);
      if (128'(cand) * 128'(cand) <= csq) cn = cand;
    end
    // normalise so the larger leg has its top bit at 60
    big = (dotv > cn) ? dotv : cn;
    top = 63;
    while (top > 0 && !big[top]) top--;
    if (top > 60) begin
      dotv = dotv >> (top - 60);
      cn = cn >> (top - 60);
    end else begin
      dotv = dotv << (60 - top);
      cn = cn << (60 - top);
    end
    // vectoring rotation towards the x axis
    x = longint'(dotv);
    y = longint'(cn);
    z = 0;
    for (int k = 0; k < 32; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x += dx; y -= dy; z += AtanDeg[k];
      end else begin
        x -= dx; y += dy; z -= AtanDeg[k];
      end
    end
    if (z < 0) z = 0;
    if (z <= TenDeg) r.pair_weight = 32'(interp_weight(z));
    return r;
  endfunction

  function automatic apw_item_t make_pair(longint ax, longint ay, longint az,
                                          longint bx, longint by, longint bz);
    apw_item_t it;
    it.first_x = ax[31:0]; it.first_y = ay[31:0]; it.first_z = az[31:0];
    it.second_x = bx[31:0]; it.second_y = by[31:0]; it.second_z = bz[31:0];
    return it;
  endfunction

  function automatic longint rand_coord(int bits);
    longint v;
    v = longint'($urandom()) - 64'sd2147483648;
    return v >>> (32 - bits);
  endfunction

  // nearly parallel pair with random perturbation size
  function automatic apw_item_t near_pair();
    longint a[3];
    longint n[3];
    int     sz;
    int     k;
    sz = $urandom_range(31, 4);
    k = $urandom_range(sz - 1, 0);
    for (int i = 0; i < 3; i++) begin
      a[i] = rand_coord(sz);
      n[i] = longint'($urandom_range((1 << k) * 2, 0)) - longint'(1 << k);
    end
    if ($urandom_range(1, 0)) return make_pair(a[0], a[1], a[2], a[0] + n[0], a[1] + n[1], a[2] + n[2]);
    return make_pair(a[0] + n[0], a[1] + n[1], a[2] + n[2], a[0], a[1], a[2]);
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // reset and stimulus
  initial begin
    apw_item_t it;
    int        sel;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    stim_done = 1'b0;
    pending_pairs.push_back(make_pair(0, 0, 0, 5, 6, 7));
    pending_pairs.push_back(make_pair(5, 6, 7, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(1, 0, 0, 1, 0, 0));
    pending_pairs.push_back(make_pair(1, 0, 0, -1, 0, 0));
    pending_pairs.push_back(make_pair(1, 0, 0, 0, 1, 0));
    pending_pairs.push_back(make_pair(1, 0, 0, 1, 1, 0));
    pending_pairs.push_back(make_pair(1000, 0, 0, 1000, 100, 0));
    pending_pairs.push_back(make_pair(100000, 0, 0, 100000, 17000, 0));
    pending_pairs.push_back(make_pair(100000, 0, 0, 100000, 17700, 0));
    pending_pairs.push_back(make_pair(1000000, 0, 0, 1000000, 30, 0));
    pending_pairs.push_back(make_pair(1000000000, 0, 0, 1000000000, 1, 0));
    pending_pairs.push_back(make_pair(2147483647, 2147483647, 2147483647,
                                      2147483647, 2147483647, 2147483647));
    pending_pairs.push_back(make_pair(-2147483648, -2147483648, -2147483648,
                                      -2147483648, -2147483648, -2147483648));
    pending_pairs.push_back(make_pair(2147483647, 2147483647, 2147483647,
                                      -2147483648, -2147483648, -2147483648));
    pending_pairs.push_back(make_pair(-2147483648, 2147483647, -2147483648,
                                      -2147483648, 2147483647, -2147483647));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1));
    pending_pairs.push_back(make_pair(3, 4, 0, 4, 3, 0));
    pending_pairs.push_back(make_pair(7, 0, 0, 7, 1, 1));
    pending_pairs.push_back(make_pair(2147483647, 0, 0, 2147483647, 3000000, 0));
    for (int n = 0; n < 1500; n++) begin
      sel = $urandom_range(99, 0);
      if (sel < 55) begin
        it = near_pair();
      end else if (sel < 85) begin
        it = make_pair(rand_coord(32), rand_coord(32), rand_coord(32),
                       rand_coord(32), rand_coord(32), rand_coord(32));
      end else if (sel < 92) begin
        it = make_pair(rand_coord(8), rand_coord(8), rand_coord(8),
                       rand_coord(8), rand_coord(8), rand_coord(8));
      end else begin
        it = near_pair();
        if ($urandom_range(1, 0)) begin
          it.first_x = 0; it.first_y = 0; it.first_z = 0;
        end else begin
          it.second_x = 0; it.second_y = 0; it.second_z = 0;
        end
      end
      pending_pairs.push_back(it);
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    stim_done = 1'b1;
    wait (pending_pairs.size() == 0 && issued_cnt == taken_cnt && !start);
    wait (expected_weights.size() == 0);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && expected_weights.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // timeout
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // driver: bursts of beats with random gaps, change on the falling edge
  initial begin
    issued_cnt = 0;
    burst_left = 0;
    gap_left = 0;
  end

  always @(negedge clk_i) begin
    if (stim_done && (!start || taken_cnt == issued_cnt)) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 0) ? $urandom_range(40, 1) : $urandom_range(4, 1);
        gap_left = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(6, 1);
      end
      if (burst_left == 0 && gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        item_i <= pending_pairs.pop_front();
        start <= 1'b1;
        issued_cnt++;
        burst_left--;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // predict on each accepted beat, check each result beat
  initial begin
    taken_cnt = 0;
    fail_cnt = 0;
  end

  always @(posedge clk_i) begin
    apw_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_weights.size() == 0) begin
          $error("result beat with nothing expected: pair_weight %h zero_vector %b",
                 result_o.pair_weight, result_o.zero_vector);
          fail_cnt++;
        end else begin
          want = expected_weights.pop_front();
          if (result_o.pair_weight !== want.pair_weight) begin
            $error("pair_weight expected %h actual %h", want.pair_weight, result_o.pair_weight);
            fail_cnt++;
          end
          if (result_o.zero_vector !== want.zero_vector) begin
            $error("zero_vector expected %b actual %b", want.zero_vector, result_o.zero_vector);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        expected_weights.push_back(pair_weight_of(item_i));
        taken_cnt++;
      end
    end
  end

endmodule

[angular_pair_weight_core.f]
design/apw_pkg.sv
design/apw_interp.sv
design/angular_pair_weight_core.sv
design/apw_checker.sv
bench/testbench.sv
